FILE: src/stwr_pkg.sv
// Package for the stopwatch readout: beat types, event codes, time constants
// and the reciprocal constants for the readout pipeline. No dependencies.
`default_nettype none

package stwr_pkg;

  // Default widths.
  localparam int DEF_TIME_BITS   = 48;
  localparam int DEF_QUEUE_DEPTH = 4;

  // Field widths of the beats.
  localparam int NOW_W     = 48;
  localparam int HOURS_W   = 27;
  localparam int MINUTES_W = 6;
  localparam int SECONDS_W = 6;
  localparam int TENTHS_W  = 4;

  // Milliseconds per display unit.
  localparam int unsigned MS_PER_HOUR  = 3600000;
  localparam int unsigned MS_PER_MIN   = 60000;
  localparam int unsigned MS_PER_SEC   = 1000;
  localparam int unsigned MS_PER_TENTH = 100;

  // Remainder widths: 3600000 < 2^22, 60000 < 2^16, 1000 < 2^10, 100 < 2^7.
  localparam int HOUR_REM_W  = 22;
  localparam int MIN_REM_W   = 16;
  localparam int SEC_REM_W   = 10;
  localparam int TENTH_REM_W = 7;

  // A quotient by a constant d is taken as (x * ceil(2^s / d)) >> s, where s
  // is the dividend width plus the divisor width, which is exact for every
  // dividend of that width. The hour step works on a 64-bit dividend, the
  // later steps on the remainder left by the step before.
  localparam int HOUR_SHIFT  = 64 + HOUR_REM_W;
  localparam int MIN_SHIFT   = HOUR_REM_W + MIN_REM_W;
  localparam int SEC_SHIFT   = MIN_REM_W + SEC_REM_W;
  localparam int TENTH_SHIFT = SEC_REM_W + TENTH_REM_W;

  // ceil(2^86 / 3600000), ceil(2^38 / 60000), ceil(2^26 / 1000) and
  // ceil(2^17 / 100).
  localparam logic [64:0] HOUR_RECIP  = {1'b1, 64'd3045270497217189268};
  localparam logic [22:0] MIN_RECIP   = 23'd4581299;
  localparam logic [16:0] SEC_RECIP   = 17'd67109;
  localparam logic [10:0] TENTH_RECIP = 11'd1311;

  // Event kinds. The unused code behaves as a read.
  localparam logic [1:0] KIND_TOGGLE = 2'd0;
  localparam logic [1:0] KIND_RESET  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [NOW_W-1:0] now_ms;
  } evt_t;

  typedef struct packed {
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
    logic [TENTHS_W-1:0]  tenths;
    logic                 running;
  } readout_t;

endpackage

`default_nettype wire

FILE: src/stwr_front.sv
// Front end of the stopwatch readout: holds the stopwatch state and turns
// each accepted event into a queue entry. Depends on stwr_pkg.
`default_nettype none

module stwr_front import stwr_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire evt_t                 evt,
  input  wire logic                 accept,
  output logic [2*TIME_BITS:0]      entry
);

  logic                 running;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] accumulated;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] since;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] stop_total;

  logic                 running_next;
  logic [TIME_BITS-1:0] start_time_next;
  logic [TIME_BITS-1:0] accumulated_next;
  logic [TIME_BITS-1:0] base;
  logic [TIME_BITS-1:0] addend;

  always_comb begin
    now        = TIME_BITS'(evt.now_ms);
    since      = now - start_time;
    sum        = {1'b0, accumulated} + {1'b0, since};
    stop_total = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  end

  always_comb begin
    running_next     = running;
    start_time_next  = start_time;
    accumulated_next = accumulated;
    base             = accumulated;
    addend           = '0;
    case (evt.kind)
      KIND_TOGGLE: begin
        if (running) begin
          accumulated_next = stop_total;
          running_next     = 1'b0;
          base             = stop_total;
        end else begin
          start_time_next = now;
          running_next    = 1'b1;
        end
      end
      KIND_RESET: begin
        accumulated_next = '0;
        start_time_next  = now;
        base             = '0;
      end
      default: begin
        // A read, or the unused code: the running time since start is
        // added later in the back end.
        addend = running ? since : '0;
      end
    endcase
    entry = {running_next, base, addend};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      start_time  <= '0;
      accumulated <= '0;
    end else if (accept) begin
      running     <= running_next;
      start_time  <= start_time_next;
      accumulated <= accumulated_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/stwr_queue.sv
// Short first-in first-out queue between the front and back ends of the
// stopwatch readout. Uses stwr_pkg only for the default depth.
`default_nettype none

module stwr_queue import stwr_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/stwr_back.sv
// Back end of the stopwatch readout: saturating sum of the queued entry,
// then a pipelined split into hours, minutes, seconds and tenths by
// multiplication with fixed reciprocals. Depends on stwr_pkg.
`default_nettype none

module stwr_back import stwr_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [2*TIME_BITS:0] entry,
  input  wire logic               entry_avail,
  output logic                    pop,
  output logic                    disp_valid,
  input  wire logic               disp_stall,
  output readout_t                disp
);

  // Stage 0 holds the elapsed time, stages 1 to 3 form the hours, stage 4
  // the hour remainder, stages 5 and 6 the minutes, 7 and 8 the seconds and
  // stage 9 the tenths.
  localparam int NS = 10;

  localparam logic [31:0]           HR_LO  = HOUR_RECIP[31:0];
  localparam logic [32:0]           HR_HI  = HOUR_RECIP[64:32];
  localparam logic [HOUR_REM_W-1:0] HOUR_D = HOUR_REM_W'(MS_PER_HOUR);
  localparam logic [MIN_REM_W-1:0]  MIN_D  = MIN_REM_W'(MS_PER_MIN);
  localparam logic [SEC_REM_W-1:0]  SEC_D  = SEC_REM_W'(MS_PER_SEC);
  localparam int PMIN_W = HOUR_REM_W + $bits(MIN_RECIP);
  localparam int PSEC_W = MIN_REM_W + $bits(SEC_RECIP);
  localparam int PTEN_W = SEC_REM_W + $bits(TENTH_RECIP);

  logic                 adv;
  logic [NS-1:0]        vld;
  logic [NS-1:0]        run;

  logic [TIME_BITS-1:0] base;
  logic [TIME_BITS-1:0] addend;
  logic [TIME_BITS:0]   sum;

  logic [TIME_BITS-1:0]  elapsed;
  logic [63:0]           xe;
  logic [31:0]           x_lo;
  logic [31:0]           x_hi;
  logic [63:0]           pp_ll;
  logic [64:0]           pp_lh;
  logic [63:0]           pp_hl;
  logic [64:0]           pp_hh;
  logic [65:0]           mid;
  logic [64:0]           hh;
  logic [65:0]           hsum;
  logic [HOUR_REM_W-1:0] lo_p [1:3];
  logic [HOURS_W-1:0]    hours_p [3:NS-1];
  logic [HOUR_REM_W-1:0] hmul;
  logic [HOUR_REM_W-1:0] hrem_a;
  logic [HOUR_REM_W-1:0] hrem_b;
  logic [PMIN_W-1:0]     pmin;
  logic [MINUTES_W-1:0]  mins_p [5:NS-1];
  logic [MIN_REM_W-1:0]  mmul;
  logic [MIN_REM_W-1:0]  mrem_a;
  logic [MIN_REM_W-1:0]  mrem_b;
  logic [PSEC_W-1:0]     psec;
  logic [SECONDS_W-1:0]  secs_p [7:NS-1];
  logic [SEC_REM_W-1:0]  smul;
  logic [SEC_REM_W-1:0]  srem;
  logic [PTEN_W-1:0]     ptn;
  logic [TENTHS_W-1:0]   tenths_q;

  // The whole pipeline moves together whenever the last stage can empty.
  assign adv = !vld[NS-1] || !disp_stall;
  assign pop = adv && entry_avail;

  assign base   = entry[2*TIME_BITS-1:TIME_BITS];
  assign addend = entry[TIME_BITS-1:0];
  assign sum    = {1'b0, base} + {1'b0, addend};

  // The 64 by 65 bit hour product is built from four partial products.
  assign xe   = 64'(elapsed);
  assign x_lo = xe[31:0];
  assign x_hi = xe[63:32];
  assign hsum = 66'(hh) + 66'(mid[65:32]);

  // Remainders are exact in their narrow width, so the products only need
  // their low bits.
  assign hmul = hours_p[3][HOUR_REM_W-1:0] * HOUR_D;
  assign pmin = PMIN_W'(hrem_a) * PMIN_W'(MIN_RECIP);
  assign mmul = MIN_REM_W'(mins_p[5]) * MIN_D;
  assign psec = PSEC_W'(mrem_a) * PSEC_W'(SEC_RECIP);
  assign smul = SEC_REM_W'(secs_p[7]) * SEC_D;
  assign ptn  = PTEN_W'(srem) * PTEN_W'(TENTH_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], entry_avail};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      run     <= {run[NS-2:0], entry[2*TIME_BITS]};
      elapsed <= sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

      pp_ll   <= 64'(x_lo) * 64'(HR_LO);
      pp_lh   <= 65'(x_lo) * 65'(HR_HI);
      pp_hl   <= 64'(x_hi) * 64'(HR_LO);
      pp_hh   <= 65'(x_hi) * 65'(HR_HI);
      lo_p[1] <= elapsed[HOUR_REM_W-1:0];

      mid     <= 66'(pp_lh) + 66'(pp_hl) + 66'(pp_ll[63:32]);
      hh      <= pp_hh;
      lo_p[2] <= lo_p[1];

      hours_p[3] <= hsum[HOUR_SHIFT-64 +: HOURS_W];
      lo_p[3]    <= lo_p[2];

      hrem_a <= lo_p[3] - hmul;

      mins_p[5] <= pmin[MIN_SHIFT +: MINUTES_W];
      hrem_b    <= hrem_a;

      mrem_a <= hrem_b[MIN_REM_W-1:0] - mmul;

      secs_p[7] <= psec[SEC_SHIFT +: SECONDS_W];
      mrem_b    <= mrem_a;

      srem <= mrem_b[SEC_REM_W-1:0] - smul;

      tenths_q <= ptn[TENTH_SHIFT +: TENTHS_W];

      for (int i = 4; i < NS; i++) begin
        hours_p[i] <= hours_p[i-1];
      end
      for (int i = 6; i < NS; i++) begin
        mins_p[i] <= mins_p[i-1];
      end
      for (int i = 8; i < NS; i++) begin
        secs_p[i] <= secs_p[i-1];
      end
    end
  end

  assign disp_valid   = vld[NS-1];
  assign disp.hours   = hours_p[NS-1];
  assign disp.minutes = mins_p[NS-1];
  assign disp.seconds = secs_p[NS-1];
  assign disp.tenths  = tenths_q;
  assign disp.running = run[NS-1];

endmodule

`default_nettype wire

FILE: src/stopwatch_timer_readout_core.sv
// Top level of the stopwatch readout: front end, queue and readout pipeline.
// Depends on stwr_pkg, stwr_front, stwr_queue and stwr_back.
//
// Usage. Events arrive on the evt channel (evt_valid, evt_stall, evt) as
// beats carrying a kind (start/stop toggle, reset, read) and the current
// uptime in milliseconds. Every accepted event yields exactly one readout
// beat on the disp channel (disp_valid, disp_stall, disp): elapsed hours,
// minutes, seconds, tenths and the running flag as they stand after that
// event. A beat moves at a rising edge with valid high and stall low.
// Throughput is one event per cycle while evt_stall is low. An event
// updates the stopwatch state in the cycle it is accepted; its readout
// passes through the queue and then the readout pipeline, which splits
// the elapsed time by multiplying with fixed reciprocals. Reset stops the
// stopwatch, clears the start and accumulated times and empties the queue
// and the pipeline. While disp_stall is high the pipeline keeps advancing
// as a whole until a beat waits at its output and then holds; the queue
// then fills to QUEUE_DEPTH entries before evt_stall rises.
`default_nettype none

module stopwatch_timer_readout_core import stwr_pkg::*; #(
  parameter int TIME_BITS   = DEF_TIME_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     evt_valid,
  output logic          evt_stall,
  input  wire evt_t     evt,
  output logic          disp_valid,
  input  wire logic     disp_stall,
  output readout_t      disp
);

  // A queue entry carries the running flag after the event, the base time
  // and the time still to be added to it.
  localparam int ENTRY_W = 2 * TIME_BITS + 1;

  logic               accept;
  logic [ENTRY_W-1:0] push_data;
  logic [ENTRY_W-1:0] pop_data;
  logic               q_full;
  logic               q_not_empty;
  logic               pop;

  // The queue being full is the only reason to hold events back.
  assign evt_stall = q_full;
  assign accept    = evt_valid && !q_full;

  stwr_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .evt    (evt),
    .accept (accept),
    .entry  (push_data)
  );

  stwr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // The back end pops an entry whenever its first stage can take one.
  stwr_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (pop_data),
    .entry_avail (q_not_empty),
    .pop         (pop),
    .disp_valid  (disp_valid),
    .disp_stall  (disp_stall),
    .disp        (disp)
  );

endmodule

`default_nettype wire

FILE: src/stwr_checker.sv
// Port-level checks for the stopwatch readout, bound to the top level.
// Depends on stwr_pkg and stopwatch_timer_readout_core.
`default_nettype none

module stwr_checker import stwr_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     evt_valid,
  input wire logic     evt_stall,
  input wire logic     disp_valid,
  input wire logic     disp_stall,
  input wire readout_t disp
);

  logic       evt_beat;
  logic       disp_beat;
  logic [7:0] outstanding;

  assign evt_beat  = evt_valid && !evt_stall;
  assign disp_beat = disp_valid && !disp_stall;

  // Events accepted whose readout has not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 8'(evt_beat) - 8'(disp_beat);
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !disp_valid)
    else $error("readout valid after reset");

  a_disp_holds: assert property (@(posedge clk) disp_valid && disp_stall
      |=> disp_valid && $stable(disp) )
    else $error("stalled readout beat changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
      disp_beat |-> outstanding != 8'd0)
    else $error("readout beat without a pending event");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
      disp_valid |-> disp.minutes < 6'd60 && disp.seconds < 6'd60 &&
      disp.tenths < 4'd10)
    else $error("readout field out of range");

endmodule

bind stopwatch_timer_readout_core stwr_checker u_stwr_checker (
  .clk        (clk),
  .rst        (rst),
  .evt_valid  (evt_valid),
  .evt_stall  (evt_stall),
  .disp_valid (disp_valid),
  .disp_stall (disp_stall),
  .disp       (disp)
);

`default_nettype wire
